### rtl/u8d_pkg.sv
package u8d_pkg;

    localparam int unsigned SCALAR_W = 21;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TDATA_W  = 24;
    localparam int unsigned COUNT_W  = 3;

    localparam logic [SCALAR_W-1:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10FFFF;

    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;

    localparam logic [SCALAR_W-1:0] MIN_THREE = 21'h000800;
    localparam logic [SCALAR_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [SCALAR_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [SCALAR_W-1:0] MIN_FOUR  = 21'h010000;

    localparam logic [1:0] TAILS_NONE  = 2'd0;
    localparam logic [1:0] TAILS_ONE   = 2'd1;
    localparam logic [1:0] TAILS_TWO   = 2'd2;
    localparam logic [1:0] TAILS_THREE = 2'd3;

endpackage

### rtl/utf8_scalar_decoder_top.sv
// utf8 byte stream to unicode scalar decoder
// input channel: one byte per transaction on s_tdata[7:0]; s_tlast marks the
// final byte of a string and flushes any sequence still open after it
// result channel: one scalar per transaction on m_tdata[20:0]; m_tlast marks
// the last result caused by an input byte, m_tuser[0] the final scalar of a
// string. a byte that only opens or extends a sequence gives no result
// a byte is accepted into the input register, decoded from there, and its
// results are loaded into the result register that drives m_tvalid
// throughput: one byte per cycle while each byte gives at most one result
// and m_tready stays high; a byte that gives n results (n up to 4, error
// bursts of U+FFFD) holds the result register for n transactions and
// stalls the input side until the last is taken; reset (aresetn low at a
// clock edge) drops both pipeline registers and closes any open sequence
// when the receiver stalls the result register holds, the input register
// fills behind it and then s_tready falls; nothing is lost
module utf8_scalar_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8d_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] byte_value
    input  logic                          s_tlast,   // string_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8d_pkg::TDATA_W-1:0]   m_tdata,   // [20:0] scalar, [23:21] zero
    output logic                          m_tlast,   // last_of_run
    output logic [0:0]                    m_tuser    // [0] string_done
);
    import u8d_pkg::*;

    // input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_end_reg;

    // decoder state
    logic [1:0]          exp_reg, exp_next;
    logic [1:0]          gat_reg, gat_next;
    logic [SCALAR_W-1:0] part_reg, part_next;

    // result register: remaining count, final value, string end
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_rem_reg;
    logic [SCALAR_W-1:0] out_val_reg;
    logic                out_end_reg;

    logic                tail, pending, complete, value_ok;
    logic [2:0]          gat_inc;
    logic [SCALAR_W-1:0] new_part;
    logic [COUNT_W-1:0]  nrep, count;
    logic                has_val;
    logic [SCALAR_W-1:0] fin_val;
    logic                lead_phase;
    logic                out_free, fire;

    assign out_free = !out_valid_reg || (m_tready && out_rem_reg == COUNT_W'(1));
    assign fire     = in_valid_reg && (count == '0 || out_free);
    assign s_tready = !in_valid_reg || fire;

    assign tail     = in_byte_reg[7:6] == 2'b10;
    assign pending  = exp_reg != TAILS_NONE;
    assign gat_inc  = {1'b0, gat_reg} + 3'd1;
    assign new_part = {part_reg[SCALAR_W-7:0], in_byte_reg[5:0]};
    assign complete = pending && tail && gat_inc == {1'b0, exp_reg};

    always_comb begin
        value_ok = 1'b1;
        if (exp_reg == TAILS_TWO) begin
            value_ok = !(new_part < MIN_THREE || (new_part >= SURR_LO && new_part <= SURR_HI));
        end else if (exp_reg == TAILS_THREE) begin
            value_ok = !(new_part < MIN_FOUR || new_part > MAX_SCALAR);
        end
    end

    always_comb begin
        exp_next   = exp_reg;
        gat_next   = gat_reg;
        part_next  = part_reg;
        nrep       = '0;
        has_val    = 1'b0;
        fin_val    = REPL_CHAR;
        lead_phase = 1'b0;

        if (pending && tail) begin
            if (complete) begin
                if (value_ok) begin
                    has_val = 1'b1;
                    fin_val = new_part;
                end else begin
                    nrep = COUNT_W'(exp_reg) + COUNT_W'(1);
                end
                exp_next  = TAILS_NONE;
                gat_next  = '0;
                part_next = '0;
            end else begin
                gat_next  = gat_inc[1:0];
                part_next = new_part;
            end
        end else if (pending) begin
            // broken sequence: flush lead and gathered tails, then decode afresh
            nrep       = COUNT_W'(gat_reg) + COUNT_W'(1);
            exp_next   = TAILS_NONE;
            gat_next   = '0;
            part_next  = '0;
            lead_phase = 1'b1;
        end else begin
            lead_phase = 1'b1;
        end

        if (lead_phase) begin
            if (!in_byte_reg[7]) begin
                has_val = 1'b1;
                fin_val = SCALAR_W'(in_byte_reg);
            end else if (in_byte_reg >= LEAD2_LO && in_byte_reg <= LEAD2_HI) begin
                exp_next  = TAILS_ONE;
                gat_next  = '0;
                part_next = SCALAR_W'(in_byte_reg[4:0]);
            end else if (in_byte_reg >= LEAD3_LO && in_byte_reg <= LEAD3_HI) begin
                exp_next  = TAILS_TWO;
                gat_next  = '0;
                part_next = SCALAR_W'(in_byte_reg[3:0]);
            end else if (in_byte_reg >= LEAD4_LO && in_byte_reg <= LEAD4_HI) begin
                exp_next  = TAILS_THREE;
                gat_next  = '0;
                part_next = SCALAR_W'(in_byte_reg[2:0]);
            end else begin
                nrep = nrep + COUNT_W'(1);
            end
        end

        // end of string flushes whatever is still open
        if (in_end_reg && exp_next != TAILS_NONE) begin
            nrep      = nrep + COUNT_W'(gat_next) + COUNT_W'(1);
            exp_next  = TAILS_NONE;
            gat_next  = '0;
            part_next = '0;
        end
    end

    assign count = nrep + COUNT_W'(has_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            exp_reg       <= TAILS_NONE;
            gat_reg       <= '0;
            part_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_rem_reg   <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                exp_reg  <= exp_next;
                gat_reg  <= gat_next;
                part_reg <= part_next;
            end
            if (fire && count != '0) begin
                out_valid_reg <= 1'b1;
                out_rem_reg   <= count;
            end else if (m_tvalid && m_tready) begin
                if (out_rem_reg == COUNT_W'(1)) begin
                    out_valid_reg <= 1'b0;
                end
                out_rem_reg <= out_rem_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (fire && count != '0) begin
            out_val_reg <= fin_val;
            out_end_reg <= in_end_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = out_rem_reg == COUNT_W'(1);
    assign m_tuser[0] = m_tlast && out_end_reg;
    assign m_tdata    = TDATA_W'(m_tlast ? out_val_reg : REPL_CHAR);

endmodule

### rtl/u8d_checker.sv
module u8d_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [u8d_pkg::BYTE_W-1:0]  s_tdata,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [u8d_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic [0:0]                  m_tuser
);
    import u8d_pkg::*;

    // a stalled result holds its whole transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // only the last result of a byte can be a decoded scalar
    a_burst_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata == TDATA_W'(REPL_CHAR))
        else $error("non-final result is not U+FFFD");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("string end flagged before last result of byte");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= TDATA_W'(MAX_SCALAR))
        else $error("scalar out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_scalar_decoder_top u8d_checker u_u8d_checker (.*);

### dv/tb_utf8_scalar_decoder_top.sv
module tb_utf8_scalar_decoder_top;
    import u8d_pkg::*;

    localparam int unsigned CLK_PERIOD = 12;
    localparam int unsigned MAX_IDLE   = 17;
    localparam int unsigned RANDOM_END = 225;
    localparam int unsigned HOLD_AFTER = 100;
    localparam int unsigned HOLD_LEN   = 160;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              string_end;
        int                gap;
        bit                drain_first;
    } byte_item_t;

    typedef struct packed {
        logic [SCALAR_W-1:0] scalar;
        logic                last_of_run;
        logic                string_done;
    } scalar_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic [0:0]          m_tuser;

    byte_item_t          pending_bytes[$];
    scalar_result_t      expected_scalars[$];
    logic [SCALAR_W-1:0] decoded_run[$];

    // decoder state mirrored on the prediction side
    logic [1:0]          open_tails = TAILS_NONE;
    logic [1:0]          got_tails  = '0;
    logic [SCALAR_W-1:0] open_value = '0;

    int unsigned         bytes_accepted = 0;
    int unsigned         total_bytes = 0;
    int unsigned         error_count = 0;
    int unsigned         hold_cycles = 0;
    bit                  hold_done = 1'b0;
    bit                  segment_idle = 1'b0;
    bit                  drain_request = 1'b0;

    int                  gap_left = 0;
    bit                  gap_armed = 1'b0;
    bit                  send_next;
    byte_item_t          next_item;

    int                  rx_stall = 0;
    bit                  rx_steady = 1'b1;
    int unsigned         results_seen = 0;
    scalar_result_t      observed;
    scalar_result_t      wanted;

    utf8_scalar_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] byte_value
        .s_tlast  (s_tlast),    // string_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [20:0] scalar, [23:21] zero
        .m_tlast  (m_tlast),    // last_of_run
        .m_tuser  (m_tuser)     // [0] string_done
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------
    task automatic close_sequence();
        open_tails = TAILS_NONE;
        got_tails  = '0;
        open_value = '0;
    endtask

    task automatic push_replacements(input int count);
        repeat (count) decoded_run.push_back(REPL_CHAR);
    endtask

    task automatic start_or_emit(input logic [BYTE_W-1:0] b);
        if (b < 8'h80) begin
            decoded_run.push_back({13'd0, b});
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            open_tails = TAILS_ONE;
            got_tails  = '0;
            open_value = {16'd0, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            open_tails = TAILS_TWO;
            got_tails  = '0;
            open_value = {17'd0, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            open_tails = TAILS_THREE;
            got_tails  = '0;
            open_value = {18'd0, b[2:0]};
        end else begin
            decoded_run.push_back(REPL_CHAR);
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic string_end);
        bit             in_range;
        scalar_result_t entry;
        decoded_run = {};
        if (open_tails != TAILS_NONE) begin
            if (b[7:6] == 2'b10) begin
                open_value = {open_value[SCALAR_W-7:0], b[5:0]};
                got_tails  = got_tails + 2'd1;
                if (got_tails == open_tails) begin
                    in_range = 1'b1;
                    if (open_tails == TAILS_TWO)
                        in_range = !(open_value < MIN_THREE ||
                                     (open_value >= SURR_LO && open_value <= SURR_HI));
                    else if (open_tails == TAILS_THREE)
                        in_range = !(open_value < MIN_FOUR || open_value > MAX_SCALAR);
                    if (in_range)
                        decoded_run.push_back(open_value);
                    else
                        push_replacements(int'(open_tails) + 1);
                    close_sequence();
                end
            end else begin
                // broken sequence: lead and gathered tails rejected, byte read afresh
                push_replacements(int'(got_tails) + 1);
                close_sequence();
                start_or_emit(b);
            end
        end else begin
            start_or_emit(b);
        end
        if (string_end && open_tails != TAILS_NONE) begin
            push_replacements(int'(got_tails) + 1);
            close_sequence();
        end
        foreach (decoded_run[k]) begin
            entry.scalar      = decoded_run[k];
            entry.last_of_run = (k == decoded_run.size() - 1);
            entry.string_done = entry.last_of_run && string_end;
            expected_scalars.push_back(entry);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    task automatic add_byte(input logic [BYTE_W-1:0] value, input logic string_end);
        byte_item_t item;
        item.value       = value;
        item.string_end  = string_end;
        item.gap         = segment_idle ? $urandom_range(0, MAX_IDLE) : 0;
        item.drain_first = drain_request;
        drain_request    = 1'b0;
        pending_bytes.push_back(item);
    endtask

    // encodes a scalar, dropping the last few tails to cut the sequence short
    task automatic add_scalar(input logic [SCALAR_W-1:0] cp, input int drop,
                              input logic string_end);
        logic [BYTE_W-1:0] enc[4];
        int                len;
        int                keep;
        if (cp < 21'h80) begin
            len = 1;
            enc[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            len = 2;
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            len = 3;
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
        end else begin
            len = 4;
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
        end
        keep = (drop >= len) ? 1 : len - drop;
        for (int i = 0; i < keep; i++)
            add_byte(enc[i], string_end && (i == keep - 1));
    endtask

    function automatic logic [SCALAR_W-1:0] random_scalar();
        logic [SCALAR_W-1:0] cp;
        case ($urandom_range(0, 3))
            0: cp = SCALAR_W'($urandom_range(0, 8'h7F));
            1: cp = SCALAR_W'($urandom_range(8'h80, 12'h7FF));
            2: begin
                cp = SCALAR_W'($urandom_range(MIN_THREE, 16'hFFFF));
                // move surrogates up out of their range
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp ^ 21'h002000;
            end
            default: cp = SCALAR_W'($urandom_range(MIN_FOUR, MAX_SCALAR));
        endcase
        return cp;
    endfunction

    // lead and tails that assemble into an overlong, surrogate or too large value
    task automatic add_bad_value(input logic string_end);
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] second;
        int                tails;
        case ($urandom_range(0, 3))
            0: begin
                lead = LEAD3_LO; second = BYTE_W'($urandom_range(8'h80, 8'h9F)); tails = 2;
            end
            1: begin
                lead = 8'hED;    second = BYTE_W'($urandom_range(8'hA0, 8'hBF)); tails = 2;
            end
            2: begin
                lead = LEAD4_LO; second = BYTE_W'($urandom_range(8'h80, 8'h8F)); tails = 3;
            end
            default: begin
                lead = LEAD4_HI; second = BYTE_W'($urandom_range(8'h90, 8'hBF)); tails = 3;
            end
        endcase
        add_byte(lead, 1'b0);
        add_byte(second, 1'b0);
        for (int i = 2; i <= tails; i++)
            add_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)), string_end && (i == tails));
    endtask

    // ---------------------------------------------------------------
    // driver
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            gap_armed = 1'b0;
            gap_left  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                send_next = 1'b0;
                if (pending_bytes.size() != 0) begin
                    if (!gap_armed) begin
                        gap_left  = pending_bytes[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!(pending_bytes[0].drain_first &&
                                   expected_scalars.size() != 0)) begin
                        next_item = pending_bytes.pop_front();
                        s_tdata   <= next_item.value;
                        s_tlast   <= next_item.string_end;
                        gap_armed = 1'b0;
                        send_next = 1'b1;
                    end
                end
                s_tvalid <= send_next;
            end
        end
    end

    // long receiver hold-off once the stream is well under way
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
            hold_cycles <= HOLD_LEN;
            hold_done   <= 1'b1;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // ---------------------------------------------------------------
    // monitor
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                observed = {m_tdata[SCALAR_W-1:0], m_tlast, m_tuser[0]};
                if (expected_scalars.size() == 0) begin
                    $display("%0t: unexpected transaction scalar=%h last=%b done=%b",
                             $time, observed.scalar, observed.last_of_run,
                             observed.string_done);
                    error_count++;
                end else begin
                    wanted = expected_scalars.pop_front();
                    if (observed !== wanted) begin
                        $display("%0t: mismatch expected scalar=%h last=%b done=%b, %s%h %s%b %s%b",
                                 $time, wanted.scalar, wanted.last_of_run,
                                 wanted.string_done, "actual scalar=", observed.scalar,
                                 "last=", observed.last_of_run, "done=",
                                 observed.string_done);
                        error_count++;
                    end
                end
                results_seen++;
                // alternate between stretches of steady acceptance and random stalls
                if (results_seen % 37 == 0)
                    rx_steady = !rx_steady;
                rx_stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (rx_stall != 0) begin
                rx_stall--;
            end
            m_tready <= (rx_stall == 0) && (hold_cycles == 0);
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        int          pick;
        int          sequences;
        logic        end_flag;
        logic [20:0] cp;

        // ascii extremes, lone tail and invalid leads
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hC1, 1'b0);
        add_byte(8'hF5, 1'b0);
        add_byte(8'hFF, 1'b0);
        // largest two-byte scalar
        add_byte(8'hDF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // overlong three-byte form
        add_byte(8'hE0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        // surrogate
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b0);
        // above the unicode range
        add_byte(8'hF4, 1'b0);
        add_byte(8'h90, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        // missing tail, breaking byte decoded afresh
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'h41, 1'b0);
        // broken sequence plus a flushed new lead at string end: four results
        add_byte(8'hF3, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hF1, 1'b1);
        add_byte(8'h41, 1'b1);

        drain_request = 1'b1;
        sequences = 0;
        while (pending_bytes.size() < RANDOM_END) begin
            if (sequences % 8 == 0)
                segment_idle = ($urandom_range(0, 1) != 0);
            if (sequences == 100)
                drain_request = 1'b1;
            end_flag = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                add_scalar(random_scalar(), 0, end_flag);
            end else if (pick < 75) begin
                cp = random_scalar();
                add_scalar(cp, $urandom_range(1, 3), end_flag);
            end else if (pick < 87) begin
                add_byte(BYTE_W'($urandom_range(0, 255)), end_flag);
            end else begin
                add_bad_value(end_flag);
            end
            sequences++;
        end
        total_bytes = pending_bytes.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_accepted != total_bytes || expected_scalars.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 200000);
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule
